>>> rtl/lkv_pkg.sv
`default_nettype none
package lkv_pkg;

    localparam int DATA_W          = 32;
    localparam int CAP_W           = 4;
    localparam int MAX_ENTRIES_DEF = 8;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;    // capture key match this cycle
        logic shift_en;  // load entry from the neighbor above
        logic keep;      // loaded entry stays valid
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> rtl/lkv_cell.sv
`default_nettype none
module lkv_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire lkv_pkg::t_cell_ctl        i_ctl,
    input  wire logic [lkv_pkg::DATA_W-1:0] i_key,
    input  wire logic                      i_up_valid,
    input  wire logic [lkv_pkg::DATA_W-1:0] i_up_key,
    input  wire logic [lkv_pkg::DATA_W-1:0] i_up_value,
    output logic                           o_valid,
    output logic [lkv_pkg::DATA_W-1:0]     o_key,
    output logic [lkv_pkg::DATA_W-1:0]     o_value,
    output logic                           o_match
);
    import lkv_pkg::*;

    logic              r_valid;
    logic              r_match;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp_en) begin
                r_match <= r_valid && (r_key == i_key);
            end
            if (i_ctl.shift_en) begin
                r_valid <= i_up_valid & i_ctl.keep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            r_key   <= i_up_key;
            r_value <= i_up_value;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_match;

endmodule
`default_nettype wire

>>> rtl/lru_key_value_cache_top.sv
// each request passes three steps in order: accept, key compare, update
// requests are served one at a time: a new request is accepted only in idle, after the
//   update of the last one; the update waits while the result register is full
// reset: synchronous active-low; all slots empty, entry count zero, capacity 8
// no clearing pass: slot contents are only seen behind their valid bits
`default_nettype none
module lru_key_value_cache_top #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request stream
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [2*lkv_pkg::DATA_W-1:0] i_s_axis_tdata,  // lookup_key, write_value
    input  wire logic                        i_s_axis_tuser,   // operation
    // result stream
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [lkv_pkg::DATA_W-1:0]       o_m_axis_tdata,   // read_value
    output logic                             o_m_axis_tuser,   // hit
    // configuration
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [lkv_pkg::CAP_W-1:0]   i_cfg_wr_data     // capacity_in_use
);
    import lkv_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // one-hot sequencer
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MATCH = 3'b010,
        ST_APPLY = 3'b100
    } t_state;

    t_state r_state, n_state;

    // captured request
    logic              r_req_op;
    logic [DATA_W-1:0] r_req_key;
    logic [DATA_W-1:0] r_req_value;

    logic [CAP_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_count, n_count;

    // result register
    logic              r_out_valid;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_data;

    // cell chain wiring, index 0 is most recent
    t_cell_ctl         cell_ctl   [MAX_ENTRIES];
    logic              cell_valid [MAX_ENTRIES];
    logic [DATA_W-1:0] cell_key   [MAX_ENTRIES];
    logic [DATA_W-1:0] cell_value [MAX_ENTRIES];
    logic              cell_match_w [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] valid_vec;
    logic [MAX_ENTRIES-1:0] at_or_above;

    logic              in_beat;
    logic              out_free;
    logic              apply;
    logic              any_hit;
    logic [DATA_W-1:0] hit_value;
    logic [DATA_W-1:0] head_value;
    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  put_count;
    logic [CNT_W:0]    count_inc;
    logic [EXT_W-1:0]  cap_ext;

    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign apply           = (r_state == ST_APPLY) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_s_axis_tvalid) n_state = ST_MATCH;
            ST_MATCH: n_state = ST_APPLY;
            ST_APPLY: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // hit detection and value pick from the registered match flags
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match_vec[i] = cell_match_w[i];
            valid_vec[i] = cell_valid[i];
            hit_value    = hit_value | (cell_value[i] & {DATA_W{cell_match_w[i]}});
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            // cell i sits at or above the matched slot
            at_or_above[i] = |(match_vec & ({MAX_ENTRIES{1'b1}} << i));
        end
    end

    assign any_hit    = |match_vec;
    assign head_value = (r_req_op == OP_PUT) ? r_req_value : hit_value;

    // clamp the capacity register into 1..MAX_ENTRIES
    assign cap_ext = EXT_W'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_ext > EXT_W'(MAX_ENTRIES)) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CNT_W'(cap_ext);
        end
    end

    // new key grows the count unless that passes capacity, then the tail drops
    assign count_inc = {1'b0, r_count} + (CNT_W+1)'(1);
    assign put_count = (count_inc > {1'b0, eff_cap}) ? r_count : count_inc[CNT_W-1:0];

    always_comb begin
        n_count = r_count;
        if (apply && (r_req_op == OP_PUT) && !any_hit) begin
            n_count = put_count;
        end
    end

    // per-cell control
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            cell_ctl[i].cmp_en = (r_state == ST_MATCH);
            if (any_hit) begin
                // promote: slots down to the matched one move by one
                cell_ctl[i].shift_en = apply && at_or_above[i];
                cell_ctl[i].keep     = 1'b1;
            end else begin
                // insert: whole chain moves, slots past the new count empty
                cell_ctl[i].shift_en = apply && (r_req_op == OP_PUT);
                cell_ctl[i].keep     = (CNT_W'(i) < put_count);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            logic              up_valid;
            logic [DATA_W-1:0] up_key;
            logic [DATA_W-1:0] up_value;
            if (g == 0) begin : g_head
                // head slot takes the request key and the chosen value
                assign up_valid = 1'b1;
                assign up_key   = r_req_key;
                assign up_value = head_value;
            end else begin : g_body
                assign up_valid = cell_valid[g-1];
                assign up_key   = cell_key[g-1];
                assign up_value = cell_value[g-1];
            end
            lkv_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (cell_ctl[g]),
                .i_key      (r_req_key),
                .i_up_valid (up_valid),
                .i_up_key   (up_key),
                .i_up_value (up_value),
                .o_valid    (cell_valid[g]),
                .o_key      (cell_key[g]),
                .o_value    (cell_value[g]),
                .o_match    (cell_match_w[g])
            );
        end
    endgenerate

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (apply) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_req_op    <= i_s_axis_tuser;
            r_req_key   <= i_s_axis_tdata[DATA_W-1:0];
            r_req_value <= i_s_axis_tdata[2*DATA_W-1:DATA_W];
        end
        if (apply) begin
            r_out_hit <= any_hit;
            if (r_req_op == OP_PUT) begin
                r_out_data <= '0;
            end else if (any_hit) begin
                r_out_data <= hit_value;
            end else begin
                r_out_data <= '1;  // get miss returns minus one
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tdata  = r_out_data;

    // keys are unique, so at most one cell can match
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // occupied slots stay packed from the most recent end
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((valid_vec & (valid_vec + MAX_ENTRIES'(1))) == '0))
        else $error("valid slots not contiguous");

    // entry count tracks the valid slots
    a_count_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(valid_vec) == int'(r_count)))
        else $error("entry count out of step with valid slots");

    // an update always leaves a result beat
    a_apply_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply |=> r_out_valid)
        else $error("update without result beat");

endmodule
`default_nettype wire
